// ===== src/dcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// DC motor ramp controller package
// Widths and codes shared by the controller and its serial divider.
// ----------------------------------------------------------------------------
package dcmr_pkg;

   localparam int PWR_W   = 10;  // power in 0.1 percent units
   localparam int TOT_W   = 20;  // step counter, wide enough for relative ramps
   localparam int DIV_N_W = 32;  // dividend width of the serial divider
   localparam int DIV_D_W = 21;  // divisor width of the serial divider
   localparam int CNT_W   = 6;   // divider iteration counter

   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_RAMP    = 3'd1;
   localparam logic [2:0] ACT_CURRENT = 3'd2;
   localparam logic [2:0] ACT_SWITCH  = 3'd3;
   localparam logic [2:0] ACT_STOP    = 3'd4;

   localparam logic [1:0] DIR_OFF = 2'b00;
   localparam logic [1:0] DIR_FWD = 2'b01;
   localparam logic [1:0] DIR_REV = 2'b11;

   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_SWITCH  = 2'd1;
   localparam logic [1:0] CAUSE_OVERCUR = 2'd2;

   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_FINISHED = 2'd1;
   localparam logic [1:0] EV_AUTOSTOP = 2'd2;

   localparam logic [2:0] CSR_SCALE    = 3'd0;
   localparam logic [2:0] CSR_OFFSET   = 3'd1;
   localparam logic [2:0] CSR_STOPCUR  = 3'd2;
   localparam logic [2:0] CSR_MAXCUR   = 3'd3;
   localparam logic [2:0] CSR_HOLDOFF  = 3'd4;
   localparam logic [2:0] CSR_POS_PRES = 3'd5;
   localparam logic [2:0] CSR_NEG_PRES = 3'd6;

endpackage

// ===== src/dcmr_serial_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module dcmr_serial_div
   import dcmr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] numer,
   input  logic [DIV_D_W-1:0] denom,
   output logic               done,
   output logic [DIV_N_W-1:0] quot
);

   logic [DIV_N_W-1:0] q_ff, q_in;
   logic [DIV_D_W:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   rem_sh;
   logic               ge;

   always_comb begin
      rem_sh  = {rem_ff[DIV_D_W-1:0], q_ff[DIV_N_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         q_in   = {q_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== src/dc_motor_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// DC motor ramp controller
// Soft-start ramps, reversal, end switch and overcurrent stops for a DC motor.
// ----------------------------------------------------------------------------
// A transaction that needs no ramp arithmetic goes through EXEC and FIN; a
// ramp step runs the serial divider once and a new relative ramp twice.
// One transaction is taken at a time; the next is taken once the result has
// been registered. Reset is synchronous and restores the state, settings
// and motor registers; the latched request, working and result data
// registers are not reset.
module dc_motor_ramp_controller
   import dcmr_pkg::*;
#(
   parameter int FULL_POWER = 1000
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_target_power,
   input  logic signed [1:0] req_target_direction,
   input  logic [15:0] req_ramp_ticks,
   input  logic        req_ramp_relative,
   input  logic signed [11:0] req_current_sample,
   input  logic        req_switch_is_positive,
   input  logic        req_switch_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pwm_value,
   output logic signed [1:0] rsp_drive_direction,
   output logic [9:0]  rsp_present_power,
   output logic        rsp_ramp_busy,
   output logic [1:0]  rsp_stop_cause,
   output logic [1:0]  rsp_status_event,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Sequencer states. EXEC carries out the transaction itself; RAMPTO and
   // BEGIN set up a new ramp; the GO and WAIT states run the divider for the
   // relative step count and for each step's power; APPLY drives the step.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXEC    = 4'd1;
   localparam logic [3:0] S_RAMPTO  = 4'd2;
   localparam logic [3:0] S_BEGIN   = 4'd3;
   localparam logic [3:0] S_TOTGO   = 4'd4;
   localparam logic [3:0] S_TOTWAIT = 4'd5;
   localparam logic [3:0] S_MUL     = 4'd6;
   localparam logic [3:0] S_STPGO   = 4'd7;
   localparam logic [3:0] S_STPWAIT = 4'd8;
   localparam logic [3:0] S_APPLY   = 4'd9;
   localparam logic [3:0] S_FIN     = 4'd10;

   localparam logic [PWR_W-1:0] FULL_P = PWR_W'(FULL_POWER);

   logic [3:0] state_ff, state_in;

   // Latched transaction
   logic [2:0]  act_ff, act_in;
   logic [9:0]  tp_ff, tp_in;
   logic [1:0]  tdir_ff, tdir_in;
   logic [15:0] tticks_ff, tticks_in;
   logic        trel_ff, trel_in;
   logic [11:0] cur_ff, cur_in;
   logic        swpos_ff, swpos_in;
   logic        swlvl_ff, swlvl_in;

   // Configuration
   logic [15:0] scale_ff, scale_in;
   logic [15:0] offset_ff, offset_in;
   logic [11:0] stopcur_ff, stopcur_in;
   logic [11:0] maxcur_ff, maxcur_in;
   logic [15:0] holdoff_ff, holdoff_in;
   logic        pospres_ff, pospres_in;
   logic        negpres_ff, negpres_in;

   // Motor state
   logic [PWR_W-1:0] power_ff, power_in;
   logic [1:0]       dir_ff, dir_in;
   logic [PWR_W-1:0] start_ff, start_in;
   logic [PWR_W-1:0] target_ff, target_in;
   logic [TOT_W-1:0] idx_ff, idx_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic             running_ff, running_in;
   logic             rev_ff, rev_in;
   logic [PWR_W-1:0] pend_p_ff, pend_p_in;
   logic [1:0]       pend_dir_ff, pend_dir_in;
   logic [15:0]      pend_ticks_ff, pend_ticks_in;
   logic             pend_rel_ff, pend_rel_in;
   logic [31:0]      tick_ff, tick_in;
   logic [31:0]      mon_ff, mon_in;
   logic             poslvl_ff, poslvl_in;
   logic             neglvl_ff, neglvl_in;
   logic [1:0]       cause_ff, cause_in;
   logic [1:0]       ev_ff, ev_in;

   // Ramp set-up working registers
   logic [PWR_W-1:0]   rt_p_ff, rt_p_in;
   logic [1:0]         rt_dir_ff, rt_dir_in;
   logic [15:0]        rt_ticks_ff, rt_ticks_in;
   logic               rt_rel_ff, rt_rel_in;
   logic [PWR_W-1:0]   bp_p_ff, bp_p_in;
   logic [15:0]        bp_ticks_ff, bp_ticks_in;
   logic               bp_rel_ff, bp_rel_in;
   logic [DIV_N_W-1:0] prod_ff, prod_in;
   logic [PWR_W-1:0]   sp_ff, sp_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] o_pwm_ff, o_pwm_in;
   logic [1:0]  o_dir_ff, o_dir_in;
   logic [9:0]  o_pwr_ff, o_pwr_in;
   logic        o_busy_ff, o_busy_in;
   logic [1:0]  o_cause_ff, o_cause_in;
   logic [1:0]  o_ev_ff, o_ev_in;

   // Divider connection
   logic               div_start;
   logic [DIV_N_W-1:0] div_num;
   logic [DIV_D_W-1:0] div_den;
   logic               div_done;
   logic [DIV_N_W-1:0] div_quot;

   // Helpers
   logic [PWR_W-1:0] ap_p;
   logic [31:0]      ap_tick;
   logic             ap_stop;
   logic             do_apply;
   logic [PWR_W-1:0] mag_b, mag_s, part;
   logic [11:0]      cur_abs;
   logic [31:0]      since;
   logic [1:0]       in_dir;
   logic [25:0]      pwm_prod;
   logic [18:0]      pwm_sum;

   dcmr_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign div_start = (state_ff == S_TOTGO) || (state_ff == S_STPGO);
   assign div_num   = prod_ff;
   assign div_den   = (state_ff == S_STPGO) ? {total_ff, 1'b0} : DIV_D_W'(FULL_POWER);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      // Shared pieces of arithmetic
      ap_p     = (state_ff == S_APPLY) ? sp_ff : target_ff;
      ap_tick  = (state_ff == S_EXEC) ? tick_ff + 32'd1 : tick_ff;
      ap_stop  = (ap_p != '0) &&
                 (((dir_ff == DIR_REV) && negpres_ff && neglvl_ff) ||
                  ((dir_ff == DIR_FWD) && pospres_ff && poslvl_ff));
      mag_b    = (bp_p_ff >= power_ff) ? bp_p_ff - power_ff : power_ff - bp_p_ff;
      mag_s    = (target_ff >= start_ff) ? target_ff - start_ff : start_ff - target_ff;
      part     = div_quot[PWR_W-1:0];
      cur_abs  = cur_ff[11] ? (~cur_ff + 12'd1) : cur_ff;
      since    = tick_ff - mon_ff;
      in_dir   = (tdir_ff == DIR_OFF) ? DIR_OFF : ((tdir_ff == DIR_FWD) ? DIR_FWD : DIR_REV);
      pwm_prod = (26'(power_ff) * 26'(scale_ff)) + 26'd128;
      pwm_sum  = 19'(offset_ff) + 19'(pwm_prod[25:8]);
      do_apply = 1'b0;

      state_in      = state_ff;
      act_in        = act_ff;
      tp_in         = tp_ff;
      tdir_in       = tdir_ff;
      tticks_in     = tticks_ff;
      trel_in       = trel_ff;
      cur_in        = cur_ff;
      swpos_in      = swpos_ff;
      swlvl_in      = swlvl_ff;
      scale_in      = scale_ff;
      offset_in     = offset_ff;
      stopcur_in    = stopcur_ff;
      maxcur_in     = maxcur_ff;
      holdoff_in    = holdoff_ff;
      pospres_in    = pospres_ff;
      negpres_in    = negpres_ff;
      power_in      = power_ff;
      dir_in        = dir_ff;
      start_in      = start_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      total_in      = total_ff;
      running_in    = running_ff;
      rev_in        = rev_ff;
      pend_p_in     = pend_p_ff;
      pend_dir_in   = pend_dir_ff;
      pend_ticks_in = pend_ticks_ff;
      pend_rel_in   = pend_rel_ff;
      tick_in       = tick_ff;
      mon_in        = mon_ff;
      poslvl_in     = poslvl_ff;
      neglvl_in     = neglvl_ff;
      cause_in      = cause_ff;
      ev_in         = ev_ff;
      rt_p_in       = rt_p_ff;
      rt_dir_in     = rt_dir_ff;
      rt_ticks_in   = rt_ticks_ff;
      rt_rel_in     = rt_rel_ff;
      bp_p_in       = bp_p_ff;
      bp_ticks_in   = bp_ticks_ff;
      bp_rel_in     = bp_rel_ff;
      prod_in       = prod_ff;
      sp_in         = sp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      o_pwm_in      = o_pwm_ff;
      o_dir_in      = o_dir_ff;
      o_pwr_in      = o_pwr_ff;
      o_busy_in     = o_busy_ff;
      o_cause_in    = o_cause_ff;
      o_ev_in       = o_ev_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:    scale_in   = csr_wdata;
            CSR_OFFSET:   offset_in  = csr_wdata;
            CSR_STOPCUR:  stopcur_in = csr_wdata[11:0];
            CSR_MAXCUR:   maxcur_in  = csr_wdata[11:0];
            CSR_HOLDOFF:  holdoff_in = csr_wdata;
            CSR_POS_PRES: pospres_in = csr_wdata[0];
            CSR_NEG_PRES: negpres_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               tp_in     = req_target_power;
               tdir_in   = req_target_direction;
               tticks_in = req_ramp_ticks;
               trel_in   = req_ramp_relative;
               cur_in    = req_current_sample;
               swpos_in  = req_switch_is_positive;
               swlvl_in  = req_switch_level;
               ev_in     = EV_NONE;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (act_ff)
               ACT_TICK: begin
                  tick_in = tick_ff + 32'd1;
                  if (running_ff) begin
                     if (idx_ff >= total_ff) begin
                        // Last step: land exactly on the target.
                        do_apply = 1'b1;
                        if (!ap_stop) begin
                           running_in = 1'b0;
                           cause_in   = CAUSE_NONE;
                           if (rev_ff) begin
                              rev_in      = 1'b0;
                              rt_p_in     = pend_p_ff;
                              rt_dir_in   = pend_dir_ff;
                              rt_ticks_in = pend_ticks_ff;
                              rt_rel_in   = pend_rel_ff;
                              state_in    = S_RAMPTO;
                           end else begin
                              ev_in = EV_FINISHED;
                           end
                        end
                     end else begin
                        idx_in   = idx_ff + 1'b1;
                        state_in = S_MUL;
                     end
                  end
               end
               ACT_RAMP: begin
                  rt_p_in     = tp_ff;
                  rt_dir_in   = in_dir;
                  rt_ticks_in = tticks_ff;
                  rt_rel_in   = trel_ff;
                  state_in    = S_RAMPTO;
               end
               ACT_CURRENT: begin
                  if ((stopcur_ff != '0) && (power_ff != '0)) begin
                     if (((cur_abs >= stopcur_ff) && !since[31]) ||
                         ((maxcur_ff != '0) && (cur_abs >= maxcur_ff))) begin
                        running_in = 1'b0;
                        rev_in     = 1'b0;
                        power_in   = '0;
                        dir_in     = DIR_OFF;
                        cause_in   = CAUSE_OVERCUR;
                        ev_in      = EV_AUTOSTOP;
                     end
                  end
               end
               ACT_SWITCH: begin
                  if (swpos_ff) begin
                     poslvl_in = swlvl_ff;
                  end else begin
                     neglvl_in = swlvl_ff;
                  end
                  if (swlvl_ff && (swpos_ff ? pospres_ff : negpres_ff)) begin
                     running_in = 1'b0;
                     rev_in     = 1'b0;
                     power_in   = '0;
                     dir_in     = DIR_OFF;
                     cause_in   = CAUSE_SWITCH;
                     ev_in      = EV_AUTOSTOP;
                  end
               end
               ACT_STOP: begin
                  running_in = 1'b0;
                  rev_in     = 1'b0;
                  power_in   = '0;
                  dir_in     = DIR_OFF;
               end
               default: ;
            endcase
         end
         S_RAMPTO: begin
            cause_in   = CAUSE_NONE;
            running_in = 1'b0;
            rev_in     = 1'b0;
            bp_rel_in  = rt_rel_ff;
            if ((rt_dir_ff != dir_ff) && (power_ff != '0)) begin
               // Reversal: ramp down first, then up from the pending command.
               pend_p_in     = rt_p_ff;
               pend_dir_in   = rt_dir_ff;
               pend_ticks_in = rt_rel_ff ? rt_ticks_ff : (rt_ticks_ff >> 1);
               pend_rel_in   = rt_rel_ff;
               rev_in        = 1'b1;
               bp_p_in       = '0;
               bp_ticks_in   = rt_rel_ff ? rt_ticks_ff : (rt_ticks_ff >> 1);
            end else begin
               dir_in      = rt_dir_ff;
               bp_p_in     = (32'(rt_p_ff) > FULL_POWER) ? FULL_P : rt_p_ff;
               bp_ticks_in = rt_ticks_ff;
            end
            state_in = S_BEGIN;
         end
         S_BEGIN: begin
            start_in   = power_ff;
            target_in  = bp_p_ff;
            idx_in     = TOT_W'(1);
            running_in = 1'b1;
            prod_in    = 32'(mag_b) * 32'(bp_ticks_ff);
            if (bp_rel_ff) begin
               state_in = S_TOTGO;
            end else begin
               total_in = TOT_W'(bp_ticks_ff) + 1'b1;
               state_in = S_MUL;
            end
         end
         S_TOTGO: begin
            state_in = S_TOTWAIT;
         end
         S_TOTWAIT: begin
            if (div_done) begin
               total_in = div_quot[TOT_W-1:0] + 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Rounded step: (2 * mag * idx + total) / (2 * total)
            prod_in  = ((32'(mag_s) * 32'(idx_ff)) << 1) + 32'(total_ff);
            state_in = S_STPGO;
         end
         S_STPGO: begin
            state_in = S_STPWAIT;
         end
         S_STPWAIT: begin
            if (div_done) begin
               sp_in    = (target_ff >= start_ff) ? start_ff + part : start_ff - part;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            do_apply = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (power_ff == '0) begin
                  o_pwm_in = '0;
               end else begin
                  o_pwm_in = (pwm_sum[18:16] != 3'd0) ? 16'hFFFF : pwm_sum[15:0];
               end
               o_dir_in   = dir_ff;
               o_pwr_in   = power_ff;
               o_busy_in  = running_ff;
               o_cause_in = cause_ff;
               o_ev_in    = ev_ff;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Driving a power level, with the end switch check toward the
      // present direction and the start of the current holdoff window.
      if (do_apply) begin
         if (ap_p == '0) begin
            power_in = '0;
            dir_in   = DIR_OFF;
         end else if (ap_stop) begin
            running_in = 1'b0;
            rev_in     = 1'b0;
            power_in   = '0;
            dir_in     = DIR_OFF;
            cause_in   = CAUSE_SWITCH;
            ev_in      = EV_AUTOSTOP;
            state_in   = S_FIN;
         end else begin
            if ((stopcur_ff != '0) && (dir_ff != DIR_OFF) && (power_ff == '0)) begin
               mon_in = ap_tick + 32'(holdoff_ff);
            end
            power_in = ap_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      tp_ff       <= tp_in;
      tdir_ff     <= tdir_in;
      tticks_ff   <= tticks_in;
      trel_ff     <= trel_in;
      cur_ff      <= cur_in;
      swpos_ff    <= swpos_in;
      swlvl_ff    <= swlvl_in;
      rt_p_ff     <= rt_p_in;
      rt_dir_ff   <= rt_dir_in;
      rt_ticks_ff <= rt_ticks_in;
      rt_rel_ff   <= rt_rel_in;
      bp_p_ff     <= bp_p_in;
      bp_ticks_ff <= bp_ticks_in;
      bp_rel_ff   <= bp_rel_in;
      prod_ff     <= prod_in;
      sp_ff       <= sp_in;
      o_pwm_ff    <= o_pwm_in;
      o_dir_ff    <= o_dir_in;
      o_pwr_ff    <= o_pwr_in;
      o_busy_ff   <= o_busy_in;
      o_cause_ff  <= o_cause_in;
      o_ev_ff     <= o_ev_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         scale_ff      <= 16'd256;
         offset_ff     <= '0;
         stopcur_ff    <= '0;
         maxcur_ff     <= '0;
         holdoff_ff    <= '0;
         pospres_ff    <= 1'b0;
         negpres_ff    <= 1'b0;
         power_ff      <= '0;
         dir_ff        <= DIR_OFF;
         start_ff      <= '0;
         target_ff     <= '0;
         idx_ff        <= '0;
         total_ff      <= TOT_W'(1);
         running_ff    <= 1'b0;
         rev_ff        <= 1'b0;
         pend_p_ff     <= '0;
         pend_dir_ff   <= DIR_OFF;
         pend_ticks_ff <= '0;
         pend_rel_ff   <= 1'b0;
         tick_ff       <= '0;
         mon_ff        <= '0;
         poslvl_ff     <= 1'b0;
         neglvl_ff     <= 1'b0;
         cause_ff      <= CAUSE_NONE;
         ev_ff         <= EV_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_ff      <= scale_in;
         offset_ff     <= offset_in;
         stopcur_ff    <= stopcur_in;
         maxcur_ff     <= maxcur_in;
         holdoff_ff    <= holdoff_in;
         pospres_ff    <= pospres_in;
         negpres_ff    <= negpres_in;
         power_ff      <= power_in;
         dir_ff        <= dir_in;
         start_ff      <= start_in;
         target_ff     <= target_in;
         idx_ff        <= idx_in;
         total_ff      <= total_in;
         running_ff    <= running_in;
         rev_ff        <= rev_in;
         pend_p_ff     <= pend_p_in;
         pend_dir_ff   <= pend_dir_in;
         pend_ticks_ff <= pend_ticks_in;
         pend_rel_ff   <= pend_rel_in;
         tick_ff       <= tick_in;
         mon_ff        <= mon_in;
         poslvl_ff     <= poslvl_in;
         neglvl_ff     <= neglvl_in;
         cause_ff      <= cause_in;
         ev_ff         <= ev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pwm_value       = o_pwm_ff;
   assign rsp_drive_direction = o_dir_ff;
   assign rsp_present_power   = o_pwr_ff;
   assign rsp_ramp_busy       = o_busy_ff;
   assign rsp_stop_cause      = o_cause_ff;
   assign rsp_status_event    = o_ev_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DC motor ramp controller testbench
// Sends tick, ramp, current, switch and stop transactions with random gaps and
// response stalls, predicts every result in a behavioural model of the motor
// state and checks the responses in order, field by field.
// ----------------------------------------------------------------------------
module testbench
   import dcmr_pkg::*;
;

   localparam int FULL_PWR  = 1000;
   localparam int WD_LIMIT  = 4000;   // cycles without any transaction
   localparam int SETTLE    = 120;    // covers the slowest ramp arithmetic
   localparam int PHASES    = 8;
   localparam int PER_PHASE = 100;

   // One response as the controller reports it.
   typedef struct packed {
      logic [15:0] pwm;
      logic [1:0]  dir;
      logic [9:0]  power;
      logic        busy;
      logic [1:0]  cause;
      logic [1:0]  event_code;
   } motor_result_type;

   // One row of stimulus; a typed row carries its own expected response.
   typedef struct packed {
      logic [2:0]       action;
      logic [9:0]       power;
      logic [1:0]       dir;
      logic [15:0]      ticks;
      logic             rel;
      logic [11:0]      current;
      logic             pos;
      logic             level;
      logic             typed;
      motor_result_type want;
   } motor_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = ACT_TICK;
   logic [9:0]  req_target_power = '0;
   logic signed [1:0] req_target_direction = '0;
   logic [15:0] req_ramp_ticks = '0;
   logic        req_ramp_relative = 1'b0;
   logic signed [11:0] req_current_sample = '0;
   logic        req_switch_is_positive = 1'b0;
   logic        req_switch_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pwm_value;
   logic signed [1:0] rsp_drive_direction;
   logic [9:0]  rsp_present_power;
   logic        rsp_ramp_busy;
   logic [1:0]  rsp_stop_cause;
   logic [1:0]  rsp_status_event;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_SCALE;
   logic [15:0] csr_wdata = '0;

   // Typed expectation travelling with the transaction being offered.
   logic             cur_typed = 1'b0;
   motor_result_type cur_want = '0;

   bit               idling_on = 1'b1;
   int               errors = 0;
   motor_result_type expected_results[$];

   always #5 clock = ~clock;

   dc_motor_ramp_controller uut (.*);

   // ------------------------------------------------------------------------
   // Behavioural motor model: configuration copy and state.
   // ------------------------------------------------------------------------
   logic [15:0] cfg_scale = 16'd256, cfg_offset = '0, cfg_holdoff = '0;
   logic [11:0] cfg_stop = '0, cfg_maxstart = '0;
   bit          cfg_pos_present = 0, cfg_neg_present = 0;

   int unsigned mot_power = 0, ramp_from = 0, ramp_to_power = 0;
   int unsigned ramp_idx = 0, ramp_total = 1;
   int          mot_dir = 0, pend_dir = 0;
   bit          ramp_on = 0, reverse_on = 0, pend_rel = 0;
   int unsigned pend_power = 0, pend_ticks = 0;
   int unsigned tick_count = 0, monitor_from = 0;
   bit          pos_level = 0, neg_level = 0;
   int unsigned stop_reason = CAUSE_NONE;

   function automatic void motor_halt();
      ramp_on = 0;
      reverse_on = 0;
      mot_power = 0;
      mot_dir = 0;
   endfunction

   function automatic int trip(int unsigned cause);
      motor_halt();
      stop_reason = cause;
      return EV_AUTOSTOP;
   endfunction

   function automatic int drive_power(int unsigned p, int d);
      if (p == 0) begin
         mot_power = 0;
         mot_dir = 0;
         return EV_NONE;
      end
      if ((d < 0 && cfg_neg_present && neg_level) || (d > 0 && cfg_pos_present && pos_level))
         return trip(CAUSE_SWITCH);
      // A fresh power-up restarts the inrush hold-off window.
      if (cfg_stop != 0 && d != 0 && mot_power == 0)
         monitor_from = tick_count + cfg_holdoff;
      mot_dir = d;
      mot_power = p;
      return EV_NONE;
   endfunction

   function automatic int unsigned ramp_level();
      longint unsigned tot, idx, s, t, mag, part;
      tot = (ramp_total != 0) ? ramp_total : 1;
      idx = (ramp_idx > tot) ? tot : ramp_idx;
      s = ramp_from;
      t = ramp_to_power;
      mag = (t >= s) ? t - s : s - t;
      part = (mag * idx * 2 + tot) / (2 * tot);
      return (t >= s) ? int'(s + part) : int'(s - part);
   endfunction

   function automatic int start_ramp(int unsigned p, int unsigned ticks, bit rel);
      longint unsigned mag;
      mag = (p >= mot_power) ? p - mot_power : mot_power - p;
      if (rel)
         ramp_total = int'((mag * ticks) / FULL_PWR) + 1;
      else
         ramp_total = ticks + 1;
      ramp_from = mot_power;
      ramp_to_power = p;
      ramp_idx = 1;
      ramp_on = 1;
      return drive_power(ramp_level(), mot_dir);
   endfunction

   function automatic int command_ramp(int unsigned p, int d, int unsigned ticks, bit rel);
      stop_reason = CAUSE_NONE;
      ramp_on = 0;
      reverse_on = 0;
      if (d != mot_dir) begin
         if (mot_power != 0) begin
            // Reversal under power: ramp down first, then up the other way.
            if (!rel)
               ticks = ticks / 2;
            pend_power = p;
            pend_dir = d;
            pend_ticks = ticks;
            pend_rel = rel;
            reverse_on = 1;
            return start_ramp(0, ticks, rel);
         end
         mot_dir = d;
      end
      if (p > FULL_PWR)
         p = FULL_PWR;
      return start_ramp(p, ticks, rel);
   endfunction

   function automatic int advance_ramp();
      int ev;
      if (ramp_idx >= ramp_total) begin
         ev = drive_power(ramp_to_power, mot_dir);
         if (ev != EV_NONE)
            return ev;
         ramp_on = 0;
         stop_reason = CAUSE_NONE;
         if (reverse_on) begin
            reverse_on = 0;
            return command_ramp(pend_power, pend_dir, pend_ticks, pend_rel);
         end
         return EV_FINISHED;
      end
      ramp_idx++;
      return drive_power(ramp_level(), mot_dir);
   endfunction

   function automatic motor_result_type predict_motor(motor_cmd_type c);
      motor_result_type r;
      int ev;
      int d;
      int unsigned mag;
      longint unsigned pwm;
      bit held;
      ev = EV_NONE;
      d = (c.dir == DIR_OFF) ? 0 : ((c.dir == DIR_FWD) ? 1 : -1);
      case (c.action)
         ACT_TICK: begin
            tick_count++;
            if (ramp_on)
               ev = advance_ramp();
         end
         ACT_RAMP: ev = command_ramp(c.power, d, c.ticks, c.rel);
         ACT_CURRENT: begin
            mag = c.current[11] ? 4096 - c.current : c.current;
            if (cfg_stop != 0 && mot_power != 0) begin
               held = (tick_count - monitor_from) < 32'h8000_0000;
               if ((mag >= cfg_stop && held) || (cfg_maxstart != 0 && mag >= cfg_maxstart))
                  ev = trip(CAUSE_OVERCUR);
            end
         end
         ACT_SWITCH: begin
            if (c.pos)
               pos_level = c.level;
            else
               neg_level = c.level;
            if (c.level && (c.pos ? cfg_pos_present : cfg_neg_present))
               ev = trip(CAUSE_SWITCH);
         end
         ACT_STOP: motor_halt();
         default: ;
      endcase
      if (mot_power == 0)
         pwm = 0;
      else begin
         pwm = longint'(cfg_offset) + ((longint'(mot_power) * cfg_scale + 128) >> 8);
         if (pwm > 16'hFFFF)
            pwm = 16'hFFFF;
      end
      r.pwm = pwm[15:0];
      r.dir = mot_dir[1:0];
      r.power = mot_power[9:0];
      r.busy = ramp_on;
      r.cause = stop_reason[1:0];
      r.event_code = ev[1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response.
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      motor_result_type want, pred;
      motor_cmd_type    c;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response with no transaction outstanding", $time);
            errors++;
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            check_field("pwm_value", want.pwm, rsp_pwm_value);
            // The direction is compared as a plain two-bit code.
            check_field("drive_direction", want.dir, {14'd0, rsp_drive_direction});
            check_field("present_power", want.power, rsp_present_power);
            check_field("ramp_busy", want.busy, rsp_ramp_busy);
            check_field("stop_cause", want.cause, rsp_stop_cause);
            check_field("status_event", want.event_code, rsp_status_event);
         end
      end
      if (!reset && req_valid && req_ready) begin
         c = '{req_action, req_target_power, req_target_direction, req_ramp_ticks,
               req_ramp_relative, req_current_sample, req_switch_is_positive,
               req_switch_level, 1'b0, '0};
         pred = predict_motor(c);
         // The model still advances on a typed row so its state stays in step.
         expected_results.push_back(cur_typed ? cur_want : pred);
      end
   end

   // The watchdog ends a hung run: it counts cycles in which no transaction
   // moves on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WD_LIMIT) begin
         $display("FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // The response side stalls in short random bursts while idling is allowed.
   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   // Offer one transaction at the falling edge and hold it until accepted.
   // The task returns at the falling edge after acceptance with valid still
   // high, so back-to-back transactions need no extra edge.
   task automatic send_cmd(motor_cmd_type c);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_action = c.action;
      req_target_power = c.power;
      req_target_direction = c.dir;
      req_ramp_ticks = c.ticks;
      req_ramp_relative = c.rel;
      req_current_sample = c.current;
      req_switch_is_positive = c.pos;
      req_switch_level = c.level;
      cur_typed = c.typed;
      cur_want = c.want;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Register writes happen only once the controller has drained; the settle
   // time covers a transaction that is still busy in the serial divider.
   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SCALE:    cfg_scale = value;
         CSR_OFFSET:   cfg_offset = value;
         CSR_STOPCUR:  cfg_stop = value[11:0];
         CSR_MAXCUR:   cfg_maxstart = value[11:0];
         CSR_HOLDOFF:  cfg_holdoff = value;
         CSR_POS_PRES: cfg_pos_present = value[0];
         CSR_NEG_PRES: cfg_neg_present = value[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic load_settings(int phase);
      logic [15:0] v [7];
      case (phase)
         1: v = '{16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0FFF, 16'hFFFF, 16'd1, 16'd1};
         2: v = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
         default: begin
            v[0] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 600));
            v[1] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 200));
            v[2] = $urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom_range(1, 400));
            v[3] = $urandom_range(0, 1) == 0 ? 16'd0 : 16'($urandom_range(200, 900));
            v[4] = 16'($urandom_range(0, 6));
            v[5] = 16'($urandom_range(0, 1));
            v[6] = 16'($urandom_range(0, 1));
         end
      endcase
      for (int i = 0; i < 7; i++)
         write_reg(3'(i), v[i]);
   endtask

   // Random transaction, weighted towards ticks so ramps run to their end.
   function automatic motor_cmd_type random_cmd();
      motor_cmd_type c;
      int pick;
      c = '0;
      c.power = 10'($urandom);
      c.dir = 2'($urandom);
      c.rel = 1'($urandom);
      c.ticks = $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8));
      c.current = 12'($urandom);
      if ($urandom_range(0, 1) == 0)
         c.current = 12'(int'(cfg_stop) + $urandom_range(0, 6) - 3);
      c.pos = 1'($urandom);
      c.level = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 48)      c.action = ACT_TICK;
      else if (pick < 70) c.action = ACT_RAMP;
      else if (pick < 84) c.action = ACT_CURRENT;
      else if (pick < 93) c.action = ACT_SWITCH;
      else if (pick < 97) c.action = ACT_STOP;
      else                c.action = 3'($urandom_range(5, 7));
      return c;
   endfunction

   // Directed table: reset state, full-power step ramp, reversal, stop, the
   // unknown actions, relative ramps of zero and full length, the unused
   // direction code that is read as reverse, ignored current and switch events.
   localparam motor_result_type ZERO_RES = '0;
   motor_cmd_type directed_table [20] = '{
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b1, ZERO_RES},
      '{ACT_RAMP,    10'd1023, DIR_FWD, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b1,
        '{16'd1000, DIR_FWD, 10'd1000, 1'b1, CAUSE_NONE, EV_NONE}},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b1,
        '{16'd1000, DIR_FWD, 10'd1000, 1'b0, CAUSE_NONE, EV_FINISHED}},
      '{ACT_RAMP,    10'd500,  DIR_REV, 16'd4,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_STOP,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b1, ZERO_RES},
      '{3'd5,        10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b1, ZERO_RES},
      '{3'd7,        10'd1023, DIR_REV, 16'hFFFF,  1'b1, 12'hFFF,   1'b1, 1'b1, 1'b0, ZERO_RES},
      '{ACT_RAMP,    10'd0,    DIR_OFF, 16'hFFFF,  1'b1, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_RAMP,    10'd1000, 2'b10,   16'd10,    1'b1, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_TICK,    10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_CURRENT, 10'd0,    DIR_OFF, 16'd0,     1'b0, 12'h800,   1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_SWITCH,  10'd0,    DIR_OFF, 16'd0,     1'b0, 12'h7FF,   1'b1, 1'b1, 1'b0, ZERO_RES},
      '{ACT_RAMP,    10'd300,  DIR_FWD, 16'hFFFF,  1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES},
      '{ACT_SWITCH,  10'd0,    DIR_OFF, 16'd0,     1'b0, 12'd0,     1'b0, 1'b0, 1'b0, ZERO_RES}
   };

   // ------------------------------------------------------------------------
   // Main sequence: reset once, directed table under reset settings, then
   // random phases with fresh register settings, the last without idling.
   // ------------------------------------------------------------------------
   initial begin
      motor_cmd_type c;
      int sent;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      load_settings(0);
      // Phase zero must use the reset values, so write them back explicitly.
      write_reg(CSR_SCALE, 16'd256);
      write_reg(CSR_OFFSET, 16'd0);
      write_reg(CSR_STOPCUR, 16'd0);
      write_reg(CSR_MAXCUR, 16'd0);
      write_reg(CSR_HOLDOFF, 16'd0);
      write_reg(CSR_POS_PRES, 16'd0);
      write_reg(CSR_NEG_PRES, 16'd0);
      foreach (directed_table[i])
         send_cmd(directed_table[i]);
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         load_settings(phase);
         idling_on = (phase != PHASES);
         sent = 0;
         while (sent < PER_PHASE) begin
            c = random_cmd();
            send_cmd(c);
            // Unknown actions do nothing, so they are not counted.
            if (c.action <= ACT_STOP)
               sent++;
         end
      end
      req_valid = 1'b0;
      cur_typed = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/dcmr_pkg.sv
src/dcmr_serial_div.sv
src/dc_motor_ramp_controller.sv
tb/testbench.sv
